### rtl/jse_pkg.sv
`timescale 1ns / 1ps

package jse_pkg;

	localparam int COUNT_BITS_DEFAULT = 16;
	localparam int CAP_BITS = 16;
	localparam logic [CAP_BITS-1:0] CAP_RESET = 16'd4096;
	localparam int HEADROOM = 7;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

	localparam int STEP_BITS = 3;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_NL = 8'h0a;
	localparam logic [7:0] CH_CR = 8'h0d;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_N = 8'h6e;
	localparam logic [7:0] CH_R = 8'h72;
	localparam logic [7:0] CH_T = 8'h74;
	localparam logic [7:0] CH_U = 8'h75;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_A = 8'h61;
	localparam logic [7:0] CH_SPACE = 8'h20;

	typedef enum logic [1:0] {
		KIND_PLAIN,
		KIND_PAIR,
		KIND_UNI
	} kind_t;

	typedef struct packed {
		kind_t kind;
		logic [7:0] data;
	} desc_t;

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] r;
		if (nib < 4'd10) begin
			r = CH_ZERO + {4'd0, nib};
		end else begin
			r = CH_A + {4'd0, nib} - 8'd10;
		end
		return r;
	endfunction

endpackage

### rtl/jse_front.sv
`timescale 1ns / 1ps

module jse_front #(
	parameter int COUNT_BITS = jse_pkg::COUNT_BITS_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    in_byte,
	input  logic [jse_pkg::CAP_BITS-1:0]  cap,
	input  logic                          q_full,
	output logic                          q_push,
	output jse_pkg::desc_t                q_desc
);

	localparam int CMP_BITS =
		((COUNT_BITS > jse_pkg::CAP_BITS) ? COUNT_BITS : jse_pkg::CAP_BITS) + 1;

	logic [COUNT_BITS-1:0] count_q;
	logic [CMP_BITS-1:0]   room_sum;
	logic                  no_room;
	logic                  is_zero;
	logic                  accept;
	logic                  drop;
	logic [2:0]            n_out;
	logic [COUNT_BITS:0]   cnt_sum;

	assign in_stall = q_full;
	assign accept = in_valid && !q_full;
	assign is_zero = (in_byte == 8'd0);
	assign room_sum = CMP_BITS'(count_q) + CMP_BITS'(jse_pkg::HEADROOM);
	assign no_room = (room_sum >= CMP_BITS'(cap));
	assign drop = is_zero ? (cap == '0) : no_room;
	assign q_push = accept && !drop;

	always_comb begin
		q_desc.kind = jse_pkg::KIND_PLAIN;
		q_desc.data = in_byte;
		n_out = 3'd1;
		unique case (in_byte)
			jse_pkg::CH_QUOTE, jse_pkg::CH_BSLASH: begin
				q_desc.kind = jse_pkg::KIND_PAIR;
				n_out = 3'd2;
			end
			jse_pkg::CH_NL: begin
				q_desc.kind = jse_pkg::KIND_PAIR;
				q_desc.data = jse_pkg::CH_N;
				n_out = 3'd2;
			end
			jse_pkg::CH_CR: begin
				q_desc.kind = jse_pkg::KIND_PAIR;
				q_desc.data = jse_pkg::CH_R;
				n_out = 3'd2;
			end
			jse_pkg::CH_TAB: begin
				q_desc.kind = jse_pkg::KIND_PAIR;
				q_desc.data = jse_pkg::CH_T;
				n_out = 3'd2;
			end
			default: begin
				if (!is_zero && in_byte < jse_pkg::CH_SPACE) begin
					q_desc.kind = jse_pkg::KIND_UNI;
					n_out = 3'd6;
				end
			end
		endcase
	end

	assign cnt_sum = (COUNT_BITS+1)'(count_q) + (COUNT_BITS+1)'(n_out);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			if (is_zero) begin
				count_q <= '0;
			end else if (!no_room) begin
				count_q <= cnt_sum[COUNT_BITS] ? '1 : cnt_sum[COUNT_BITS-1:0];
			end
		end
	end

endmodule

### rtl/jse_queue.sv
`timescale 1ns / 1ps

module jse_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  jse_pkg::desc_t push_desc,
	output logic           full,
	input  logic           pop,
	output logic           empty,
	output jse_pkg::desc_t head
);

	jse_pkg::desc_t mem [jse_pkg::QUEUE_DEPTH];
	logic [jse_pkg::QUEUE_PTR_BITS-1:0] wr_q;
	logic [jse_pkg::QUEUE_PTR_BITS-1:0] rd_q;
	logic [jse_pkg::QUEUE_CNT_BITS-1:0] cnt_q;

	assign full = (cnt_q == jse_pkg::QUEUE_CNT_BITS'(jse_pkg::QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign head = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == jse_pkg::QUEUE_PTR_BITS'(jse_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == jse_pkg::QUEUE_PTR_BITS'(jse_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### rtl/jse_back.sv
`timescale 1ns / 1ps

module jse_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_empty,
	input  jse_pkg::desc_t q_head,
	output logic           q_pop,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [7:0]     out_byte,
	output logic           last_of_run
);

	logic [jse_pkg::STEP_BITS-1:0] step_q;
	logic                          out_valid_q;
	logic [7:0]                    out_byte_q;
	logic                          last_q;
	logic                          advance;
	logic [7:0]                    nxt_byte;
	logic                          nxt_last;

	assign advance = !q_empty && (!out_valid_q || !out_stall);
	assign q_pop = advance && nxt_last;

	always_comb begin
		nxt_byte = q_head.data;
		nxt_last = 1'b1;
		unique case (q_head.kind)
			jse_pkg::KIND_PLAIN: begin
				nxt_byte = q_head.data;
				nxt_last = 1'b1;
			end
			jse_pkg::KIND_PAIR: begin
				nxt_last = (step_q == 3'd1);
				nxt_byte = nxt_last ? q_head.data : jse_pkg::CH_BSLASH;
			end
			jse_pkg::KIND_UNI: begin
				nxt_last = (step_q == 3'd5);
				case (step_q)
					3'd0: nxt_byte = jse_pkg::CH_BSLASH;
					3'd1: nxt_byte = jse_pkg::CH_U;
					3'd2, 3'd3: nxt_byte = jse_pkg::CH_ZERO;
					3'd4: nxt_byte = jse_pkg::hex_char(q_head.data[7:4]);
					default: nxt_byte = jse_pkg::hex_char(q_head.data[3:0]);
				endcase
			end
			default: begin
				nxt_byte = q_head.data;
				nxt_last = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				step_q <= nxt_last ? '0 : step_q + 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_byte_q <= nxt_byte;
			last_q <= nxt_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte = out_byte_q;
	assign last_of_run = last_q;

endmodule

### rtl/json_string_escaper.sv
`timescale 1ns / 1ps
// an accepted input byte is written into the queue, then the emitter registers its first output byte
// throughput: one output byte per cycle while the queue holds entries and out_stall is low; the output
// byte stage passes a plain byte or terminator through and steps through a two-char or \u00xx escape
// a four-entry queue between classifier and emitter absorbs bursts of expansion
// reset: count, queue and output stage cleared, capacity register set to 4096

module json_string_escaper #(
	parameter int COUNT_BITS = jse_pkg::COUNT_BITS_DEFAULT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [7:0]                   in_byte,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [7:0]                   out_byte,
	output logic                         last_of_run,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [jse_pkg::CAP_BITS-1:0] cfg_data
);

	logic [jse_pkg::CAP_BITS-1:0] cap_q;
	logic                         q_full;
	logic                         q_empty;
	logic                         q_push;
	logic                         q_pop;
	jse_pkg::desc_t               q_desc;
	jse_pkg::desc_t               q_head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= jse_pkg::CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= cfg_data;
		end
	end

	jse_front #(
		.COUNT_BITS(COUNT_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_byte  (in_byte),
		.cap      (cap_q),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_desc   (q_desc)
	);

	jse_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_desc (q_desc),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.head      (q_head)
	);

	jse_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.last_of_run (last_of_run)
	);

endmodule

### bench/tb_json_string_escaper.sv
`timescale 1ns / 1ps

module tb_json_string_escaper;

	localparam int COUNT_MAX = (1 << jse_pkg::COUNT_BITS_DEFAULT) - 1;
	localparam logic [127:0] HEX_DIGITS = "0123456789abcdef";
	localparam int SCRIPT_ROWS = 26;
	localparam int PHASES = 10;
	localparam int PHASE_BYTES = 40;
	localparam int MAX_PRINTS = 100;

	typedef enum logic [1:0] {
		ROW_BYTE,
		ROW_CAP
	} row_kind_t;

	// typed_len < 0: expectation comes from the predictor
	typedef struct packed {
		row_kind_t kind;
		logic [15:0] value;
		int typed_len;
		logic [47:0] typed;
	} row_t;

	typedef struct packed {
		logic [7:0] data;
		logic last;
	} esc_out_t;

	localparam row_t SCRIPT [SCRIPT_ROWS] = '{
		'{ROW_BYTE, 16'h0041, 1, "A"},
		'{ROW_BYTE, 16'h0022, 2, "\\\""},
		'{ROW_BYTE, 16'h005c, 2, "\\\\"},
		'{ROW_BYTE, 16'h000a, 2, "\\n"},
		'{ROW_BYTE, 16'h000d, 2, "\\r"},
		'{ROW_BYTE, 16'h0009, 2, "\\t"},
		'{ROW_BYTE, 16'h0001, 6, "\\u0001"},
		'{ROW_BYTE, 16'h001f, 6, "\\u001f"},
		'{ROW_BYTE, 16'h0020, 1, " "},
		'{ROW_BYTE, 16'h00ff, 1, 48'hff},
		'{ROW_BYTE, 16'h007f, -1, 48'h0},
		'{ROW_BYTE, 16'h0080, -1, 48'h0},
		'{ROW_BYTE, 16'h000b, -1, 48'h0},
		'{ROW_BYTE, 16'h0000, 1, 48'h0},
		'{ROW_CAP, 16'h0000, -1, 48'h0},
		'{ROW_BYTE, 16'h0041, 0, 48'h0},
		'{ROW_BYTE, 16'h0000, 0, 48'h0},
		'{ROW_CAP, 16'h0007, -1, 48'h0},
		'{ROW_BYTE, 16'h0022, 0, 48'h0},
		'{ROW_BYTE, 16'h0000, 1, 48'h0},
		'{ROW_CAP, 16'h0008, -1, 48'h0},
		'{ROW_BYTE, 16'h0062, -1, 48'h0},
		'{ROW_BYTE, 16'h000a, -1, 48'h0},
		'{ROW_BYTE, 16'h0000, -1, 48'h0},
		'{ROW_CAP, 16'hffff, -1, 48'h0},
		'{ROW_BYTE, 16'h001e, -1, 48'h0}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [7:0] in_byte;
	logic out_valid;
	logic out_stall;
	logic [7:0] out_byte;
	logic last_of_run;
	logic cfg_valid;
	logic cfg_ready;
	logic [jse_pkg::CAP_BITS-1:0] cfg_data;

	logic [jse_pkg::CAP_BITS-1:0] cap_shadow;
	logic [jse_pkg::COUNT_BITS_DEFAULT-1:0] run_count;
	esc_out_t escaped_q[$];
	esc_out_t head;
	int error_count = 0;
	bit no_gaps = 1'b0;

	json_string_escaper dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_byte(in_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte(out_byte),
		.last_of_run(last_of_run),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic flag_error(input string msg);
		if (error_count < MAX_PRINTS) begin
			$display("mismatch at %0t: %s", $realtime, msg);
		end
		error_count++;
	endtask

	function automatic logic [7:0] hex_digit(input logic [3:0] nib);
		return HEX_DIGITS[8 * (15 - nib) +: 8];
	endfunction

	// escaped bytes land in the low n bytes of seq, first byte highest
	function automatic int escape_byte(input logic [7:0] c, output logic [47:0] seq);
		int n;
		int sum;
		seq = '0;
		n = 0;
		if (c == 8'h00) begin
			run_count = '0;
			n = (cap_shadow == '0) ? 0 : 1;
		end else if (int'(run_count) + jse_pkg::HEADROOM >= int'(cap_shadow)) begin
			n = 0;
		end else begin
			if (c == jse_pkg::CH_QUOTE || c == jse_pkg::CH_BSLASH) begin
				seq = {32'h0, jse_pkg::CH_BSLASH, c};
				n = 2;
			end else if (c == jse_pkg::CH_NL) begin
				seq = {32'h0, jse_pkg::CH_BSLASH, jse_pkg::CH_N};
				n = 2;
			end else if (c == jse_pkg::CH_CR) begin
				seq = {32'h0, jse_pkg::CH_BSLASH, jse_pkg::CH_R};
				n = 2;
			end else if (c == jse_pkg::CH_TAB) begin
				seq = {32'h0, jse_pkg::CH_BSLASH, jse_pkg::CH_T};
				n = 2;
			end else if (c < jse_pkg::CH_SPACE) begin
				seq = {jse_pkg::CH_BSLASH, jse_pkg::CH_U, jse_pkg::CH_ZERO,
					jse_pkg::CH_ZERO, hex_digit(c[7:4]), hex_digit(c[3:0])};
				n = 6;
			end else begin
				seq = {40'h0, c};
				n = 1;
			end
			sum = int'(run_count) + n;
			run_count = (sum > COUNT_MAX) ?
				COUNT_MAX[jse_pkg::COUNT_BITS_DEFAULT-1:0] :
				sum[jse_pkg::COUNT_BITS_DEFAULT-1:0];
		end
		return n;
	endfunction

	function automatic void push_expected(input int n, input logic [47:0] seq);
		esc_out_t e;
		for (int k = 0; k < n; k++) begin
			e.data = seq[8 * (n - 1 - k) +: 8];
			e.last = (k == n - 1);
			escaped_q.push_back(e);
		end
	endfunction

	function automatic logic [7:0] random_src_byte();
		logic [7:0] b;
		case ($urandom_range(0, 9))
			0: b = $urandom_range(0, 1) ? jse_pkg::CH_QUOTE : jse_pkg::CH_BSLASH;
			1: begin
				case ($urandom_range(0, 2))
					0: b = jse_pkg::CH_NL;
					1: b = jse_pkg::CH_CR;
					default: b = jse_pkg::CH_TAB;
				endcase
			end
			2: b = 8'($urandom_range(1, 31));
			3, 4, 5, 6: b = 8'($urandom_range(32, 126));
			7, 8: b = 8'($urandom_range(128, 255));
			default: b = 8'($urandom_range(1, 255));
		endcase
		return b;
	endfunction

	function automatic logic [15:0] pick_capacity(input int phase);
		logic [15:0] v;
		case (phase)
			0: v = 16'd12;
			1: v = 16'd0;
			2: v = 16'd30;
			3: v = 16'd5;
			4: v = 16'hffff;
			5: v = 16'd9;
			6: v = 16'($urandom_range(8, 64));
			7: v = jse_pkg::CAP_RESET;
			8: v = 16'($urandom_range(0, 65535));
			default: v = 16'd20;
		endcase
		return v;
	endfunction

	task automatic send_byte(input logic [7:0] b, input int typed_len, input logic [47:0] typed);
		int gap;
		int n;
		logic [47:0] seq;
		gap = no_gaps ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		n = escape_byte(b, seq);
		if (typed_len >= 0) begin
			push_expected(typed_len, typed);
		end else begin
			push_expected(n, seq);
		end
	endtask

	// dropped bytes leave nothing to wait on, so let the pipeline settle once the queue is empty
	task automatic drain_and_settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (escaped_q.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [15:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		cap_shadow = v;
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (escaped_q.size() == 0) begin
				flag_error($sformatf("output byte %02h with nothing expected", out_byte));
			end else begin
				head = escaped_q.pop_front();
				if (out_byte !== head.data) begin
					flag_error($sformatf("out_byte %02h, expected %02h", out_byte, head.data));
				end
				if (last_of_run !== head.last) begin
					flag_error($sformatf("last_of_run %0b, expected %0b on byte %02h",
						last_of_run, head.last, head.data));
				end
			end
		end
	end

	initial begin : rx_side
		int hold;
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			hold = no_gaps ? 0 : $urandom_range(0, 7);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				out_stall <= 1'b0;
			end
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	initial begin : watchdog
		#5000000;
		$display("json_string_escaper regression: fail");
		$finish;
	end

	initial begin : stimulus
		int r;
		int phase;
		int sent;
		int len;
		int i;
		bit cut;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_byte <= 8'h00;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		cap_shadow = jse_pkg::CAP_RESET;
		run_count = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (r = 0; r < SCRIPT_ROWS; r++) begin
			if (SCRIPT[r].kind == ROW_CAP) begin
				drain_and_settle();
				write_capacity(SCRIPT[r].value);
			end else begin
				send_byte(SCRIPT[r].value[7:0], SCRIPT[r].typed_len, SCRIPT[r].typed);
			end
		end

		// odd phases may stop mid-string so the new capacity applies to a running count
		for (phase = 0; phase < PHASES; phase++) begin
			drain_and_settle();
			no_gaps = (phase % 4 == 3);
			write_capacity(pick_capacity(phase));
			cut = (phase % 2 == 1);
			sent = 0;
			while (sent < PHASE_BYTES) begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 12);
				for (i = 0; i < len && !(cut && sent >= PHASE_BYTES); i++) begin
					send_byte(random_src_byte(), -1, '0);
					sent++;
				end
				if (!(cut && sent >= PHASE_BYTES)) begin
					send_byte(8'h00, -1, '0);
					sent++;
				end
			end
		end

		no_gaps = 1'b0;
		drain_and_settle();
		if (error_count == 0) begin
			$display("json_string_escaper regression: pass");
		end else begin
			$display("json_string_escaper regression: fail");
		end
		$finish;
	end

endmodule
